// ===== hw/rtl/nsc_pkg.sv =====
`default_nettype none

package nsc_pkg;

   // register map
   localparam int unsigned CsrAddrWidth      = 3;
   localparam int unsigned CsrDataWidth      = 32;
   localparam logic [CsrAddrWidth-1:0] REG_EXPECTED_COMMAS = 3'd0;
   localparam logic [7:0]  EXPECTED_COMMAS_RESET = 8'd14;

   // marker characters
   localparam logic [7:0] CHAR_COMMA  = 8'h2c;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2a;

   // sentence phase codes
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_BODY    = 2'd1;
   localparam logic [1:0] PH_HEX     = 2'd2;
   localparam logic [1:0] PH_BADSTAR = 2'd3;

   // verdict codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_COMMAS   = 3'd1;
   localparam logic [2:0] ST_NOSTART  = 3'd2;
   localparam logic [2:0] ST_NOSTAR   = 3'd3;
   localparam logic [2:0] ST_NOHEX    = 3'd4;
   localparam logic [2:0] ST_MISMATCH = 3'd5;

   typedef struct packed {
      logic       sentence_ok;
      logic [2:0] status;
      logic [7:0] computed_sum;
      logic [7:0] received_sum;
   } result_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_digit_type;

   // ascii hex digit decode
   function automatic hex_digit_type hex_digit(input logic [7:0] c);
      hex_digit_type d;
      d.is_hex = 1'b0;
      d.value  = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.is_hex = 1'b1;
         d.value  = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.is_hex = 1'b1;
         d.value  = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.is_hex = 1'b1;
         d.value  = 4'(c - 8'h37);
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nsc_ifs.sv =====
`default_nettype none

// byte stream channel
interface nsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       last_byte;
   modport source (output valid, output char_byte, output last_byte, input ready);
   modport sink (input valid, input char_byte, input last_byte, output ready);
endinterface

// verdict channel
interface nsc_rsp_if;
   logic       valid;
   logic       ready;
   logic       sentence_ok;
   logic [2:0] status;
   logic [7:0] computed_sum;
   logic [7:0] received_sum;
   modport source (output valid, output sentence_ok, output status,
                   output computed_sum, output received_sum, input ready);
   modport sink (input valid, input sentence_ok, input status,
                 input computed_sum, input received_sum, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nmea_sentence_checker.sv =====
`default_nettype none

// NMEA 0183 sentence checker. Bytes of a sentence arrive one per transfer on
// req_bus, the final byte marked by last_byte; one verdict per sentence leaves
// on rsp_bus (status, checksum computed over the bytes between '$' and '*',
// and the hex value read after '*'). The last byte of a sentence passes through
// the input register, then through the scan logic into the result register.
// One byte is accepted every cycle; the input stalls only when a verdict is
// due and the result register is still held by the sink.
// The expected comma count is set over the APB port at address 0 (reset 14)
// and should only be written while no sentence is in flight.
module nmea_sentence_checker
   import nsc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   nsc_req_if.sink                      req_bus,
   nsc_rsp_if.source                    rsp_bus,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CsrAddrWidth-1:0] paddr,
   input  wire logic [CsrDataWidth-1:0] pwdata,
   output logic      [CsrDataWidth-1:0] prdata,
   output logic                         pready
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type verdict;
   logic [7:0] expected_commas;
   logic       out_free;
   logic       step;

   nsc_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .expected_commas (expected_commas)
   );

   // flow control
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && (!in_last_ff || out_free);
   assign req_bus.ready = !in_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready) begin
         in_byte_ff <= req_bus.char_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   nsc_scan u_scan (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .char_byte       (in_byte_ff),
      .last_byte       (in_last_ff),
      .expected_commas (expected_commas),
      .verdict         (verdict)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step && in_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && step && in_last_ff) begin
         out_ff <= verdict;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.sentence_ok  = out_ff.sentence_ok;
   assign rsp_bus.status       = out_ff.status;
   assign rsp_bus.computed_sum = out_ff.computed_sum;
   assign rsp_bus.received_sum = out_ff.received_sum;

endmodule

`default_nettype wire

// ===== hw/rtl/nsc_csr.sv =====
`default_nettype none

module nsc_csr
   import nsc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CsrAddrWidth-1:0] paddr,
   input  wire logic [CsrDataWidth-1:0] pwdata,
   output logic      [CsrDataWidth-1:0] prdata,
   output logic                         pready,
   output logic      [7:0]              expected_commas
);

   logic [7:0] expected_commas_ff;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr == REG_EXPECTED_COMMAS);

   // register write on access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_commas_ff <= EXPECTED_COMMAS_RESET;
      end else if (wr_en) begin
         expected_commas_ff <= pwdata[7:0];
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (paddr == REG_EXPECTED_COMMAS) begin
         prdata = {{(CsrDataWidth-8){1'b0}}, expected_commas_ff};
      end
   end

   assign expected_commas = expected_commas_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/nsc_scan.sv =====
`default_nettype none

module nsc_scan
   import nsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] char_byte,
   input  wire logic       last_byte,
   input  wire logic [7:0] expected_commas,
   output result_type      verdict
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] comma_count_ff, comma_count_in;
   logic [7:0] xor_acc_ff, xor_acc_in;
   logic [7:0] hex_value_ff, hex_value_in;
   logic       hex_seen_ff, hex_seen_in;
   logic       hex_done_ff, hex_done_in;
   logic       hex_overflow_ff, hex_overflow_in;
   hex_digit_type digit;

   assign digit = hex_digit(char_byte);

   // next sentence state from this byte
   always_comb begin
      phase_in        = phase_ff;
      comma_count_in  = comma_count_ff;
      xor_acc_in      = xor_acc_ff;
      hex_value_in    = hex_value_ff;
      hex_seen_in     = hex_seen_ff;
      hex_done_in     = hex_done_ff;
      hex_overflow_in = hex_overflow_ff;

      if (char_byte == CHAR_COMMA && comma_count_ff != 8'hff) begin
         comma_count_in = comma_count_ff + 8'd1;
      end

      case (phase_ff)
         PH_IDLE: begin
            if (char_byte == CHAR_DOLLAR) begin
               phase_in = PH_BODY;
            end else if (char_byte == CHAR_STAR) begin
               phase_in = PH_BADSTAR;
            end
         end
         PH_BODY: begin
            if (char_byte == CHAR_STAR) begin
               phase_in = PH_HEX;
            end else begin
               xor_acc_in = xor_acc_ff ^ char_byte;
            end
         end
         PH_HEX: begin
            if (!hex_done_ff) begin
               if (!digit.is_hex) begin
                  hex_done_in = 1'b1;
               end else begin
                  hex_seen_in = 1'b1;
                  // value above one byte saturates
                  if (hex_overflow_ff || hex_value_ff[7:4] != 4'd0) begin
                     hex_overflow_in = 1'b1;
                     hex_value_in    = 8'hff;
                  end else begin
                     hex_value_in = {hex_value_ff[3:0], digit.value};
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // verdict in priority order
   always_comb begin
      if (comma_count_in != expected_commas) begin
         verdict.status = ST_COMMAS;
      end else if (phase_in == PH_IDLE || phase_in == PH_BADSTAR) begin
         verdict.status = ST_NOSTART;
      end else if (phase_in == PH_BODY) begin
         verdict.status = ST_NOSTAR;
      end else if (!hex_seen_in) begin
         verdict.status = ST_NOHEX;
      end else if (hex_overflow_in || hex_value_in != xor_acc_in) begin
         verdict.status = ST_MISMATCH;
      end else begin
         verdict.status = ST_OK;
      end
      verdict.sentence_ok  = (verdict.status == ST_OK);
      verdict.computed_sum = xor_acc_in;
      verdict.received_sum = hex_value_in;
   end

   // sentence state, cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff        <= PH_IDLE;
         comma_count_ff  <= '0;
         xor_acc_ff      <= '0;
         hex_value_ff    <= '0;
         hex_seen_ff     <= 1'b0;
         hex_done_ff     <= 1'b0;
         hex_overflow_ff <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         comma_count_ff  <= comma_count_in;
         xor_acc_ff      <= xor_acc_in;
         hex_value_ff    <= hex_value_in;
         hex_seen_ff     <= hex_seen_in;
         hex_done_ff     <= hex_done_in;
         hex_overflow_ff <= hex_overflow_in;
      end
   end

endmodule

`default_nettype wire
